@@ rtl/tsc_pkg.sv @@
package tsc_pkg;

   // Grammar positions: one code per position in the grammar.
   localparam logic [4:0] PH_YEAR0     = 5'd0;
   localparam logic [4:0] PH_YEAR1     = 5'd1;
   localparam logic [4:0] PH_YEAR2     = 5'd2;
   localparam logic [4:0] PH_YEAR3     = 5'd3;
   localparam logic [4:0] PH_DASH1     = 5'd4;
   localparam logic [4:0] PH_MON0      = 5'd5;
   localparam logic [4:0] PH_MON1      = 5'd6;
   localparam logic [4:0] PH_DASH2     = 5'd7;
   localparam logic [4:0] PH_DAY0      = 5'd8;
   localparam logic [4:0] PH_DAY1      = 5'd9;
   localparam logic [4:0] PH_TSEP      = 5'd10;
   localparam logic [4:0] PH_HOUR0     = 5'd11;
   localparam logic [4:0] PH_HOUR1     = 5'd12;
   localparam logic [4:0] PH_COLON1    = 5'd13;
   localparam logic [4:0] PH_MIN0      = 5'd14;
   localparam logic [4:0] PH_MIN1      = 5'd15;
   localparam logic [4:0] PH_COLON2    = 5'd16;
   localparam logic [4:0] PH_SEC0      = 5'd17;
   localparam logic [4:0] PH_SEC1      = 5'd18;
   localparam logic [4:0] PH_AFTER_SEC = 5'd19;
   localparam logic [4:0] PH_FRAC      = 5'd20;
   localparam logic [4:0] PH_ZULU_DONE = 5'd21;
   localparam logic [4:0] PH_ZHOUR0    = 5'd22;
   localparam logic [4:0] PH_ZHOUR1    = 5'd23;
   localparam logic [4:0] PH_ZCOLON    = 5'd24;
   localparam logic [4:0] PH_ZMIN0     = 5'd25;
   localparam logic [4:0] PH_ZMIN1     = 5'd26;
   localparam logic [4:0] PH_ZONE_DONE = 5'd27;

   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_DASH  = 8'h2D;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_T     = 8'h54;
   localparam logic [7:0] CH_Z     = 8'h5A;

   localparam logic [6:0] MAX_MONTH  = 7'd12;
   localparam logic [6:0] MAX_HOUR   = 7'd23;
   localparam logic [6:0] MAX_MINUTE = 7'd59;
   localparam logic [6:0] MAX_SECOND = 7'd60;

   // Parse state. The year is held as its century and its two low digits,
   // which makes the leap test a pair of two-bit masks.
   typedef struct packed {
      logic [4:0] phase;
      logic [6:0] year_hi;
      logic [6:0] year_lo;
      logic [3:0] month;
      logic [3:0] pair;
      logic       frac_seen;
      logic       failed;
   } tsc_state_type;

   function automatic logic [4:0] days_in_month(input logic [3:0] month,
                                                input logic       leap);
      logic [4:0] days;
      case (month)
         4'd2:                      days = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:   days = 5'd30;
         4'd1, 4'd3, 4'd5, 4'd7,
         4'd8, 4'd10, 4'd12:        days = 5'd31;
         default:                   days = 5'd0;
      endcase
      return days;
   endfunction

endpackage

@@ rtl/rfc3339_timestamp_check_core.sv @@
// Streaming checker for timestamps of the form YYYY-MM-DDTHH:MM:SS[.f+](Z|+HH:MM|-HH:MM).
// Input: one character per req_ transfer, req_tlast set on the final character.
// Output: one rsp_ transfer per string, sent for its last character only;
//   rsp_tdata[0] is 1 when the string is a well-formed timestamp with all
//   fields in range (day against the month, February by the 4/100/400 rule).
// Pipeline: an input register holds the accepted character, a single pass of
//   parse logic updates the state, and the verdict lands in an output register.
//   A held verdict in the output register can stall a last character in the
//   input register before its verdict is registered.
// Throughput: one character per cycle while no last character is held by a stall;
//   a character that gives no verdict never waits on the output side.
// Stall: while rsp_tready is low and a verdict is held, a last character waits
//   in the input register and req_tready drops; other characters flow on.
// Reset: synchronous, active high; clears both registers' valid flags and the
//   parse state, so the next character is taken as the first of a string.
// After a rule is broken the rest of the string is consumed without output
//   until its last character, which yields a verdict of 0.
module rfc3339_timestamp_check_core
   import tsc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] char_code
   input  logic       req_tlast,   // is_last
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata    // [0] valid_res, [7:1] zero
);

   logic          in_valid_ff, in_valid_in;
   logic [7:0]    in_char_ff;
   logic          in_last_ff;
   logic          out_valid_ff, out_valid_in;
   logic          out_res_ff;
   tsc_state_type state_ff, state_in;
   logic          step_res;
   logic          fire;

   tsc_step u_step (
      .cur_state (state_ff),
      .char_code (in_char_ff),
      .is_last   (in_last_ff),
      .nxt_state (state_in),
      .valid_res (step_res)
   );

   // Advance the held character unless it carries a verdict with nowhere to go.
   assign fire        = in_valid_ff && (!in_last_ff || !out_valid_ff || rsp_tready);
   assign req_tready  = !in_valid_ff || fire;
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !fire);
   assign out_valid_in = (fire && in_last_ff) || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (fire) state_ff <= state_in;
      end
   end

   // Payload registers: load on transfer, hold otherwise.
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_char_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (fire && in_last_ff) begin
         out_res_ff <= step_res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0, out_res_ff};

`ifndef NO_ASSERTIONS
   a_restart: assert property (@(posedge clock) disable iff (reset)
      (fire && in_last_ff) |=> (state_ff.phase == PH_YEAR0 && !state_ff.failed))
      else $error("parse state not restarted after last character");

   a_verdict_src: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(fire && in_last_ff))
      else $error("verdict raised without a last character");

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.phase <= PH_ZONE_DONE)
      else $error("parse phase out of range");

   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !fire) |=> (in_valid_ff && $stable(in_char_ff) && $stable(in_last_ff)))
      else $error("held character lost or overwritten");

   a_fail_sticky: assert property (@(posedge clock) disable iff (reset)
      (state_ff.failed && !(fire && in_last_ff)) |=> state_ff.failed)
      else $error("failure cleared before end of string");
`endif

endmodule

@@ rtl/tsc_step.sv @@
module tsc_step
   import tsc_pkg::*;
(
   input  tsc_state_type cur_state,
   input  logic [7:0]    char_code,
   input  logic          is_last,
   output tsc_state_type nxt_state,
   output logic          valid_res
);

   logic          dig;
   logic [3:0]    d;
   logic [6:0]    v;
   logic          leap;
   logic [4:0]    mdays;
   logic          zone_ok;
   logic [4:0]    zone_phase;
   tsc_state_type adv;

   assign dig  = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
   assign d    = dig ? 4'(char_code - CH_ZERO) : 4'd0;
   assign v    = 7'({3'd0, cur_state.pair} * 7'd10) + {3'd0, d};
   // Century years are leap only when the century divides by four.
   assign leap = (cur_state.year_lo == 7'd0) ? (cur_state.year_hi[1:0] == 2'd0)
                                             : (cur_state.year_lo[1:0] == 2'd0);
   assign mdays = days_in_month(cur_state.month, leap);
   assign zone_ok    = (char_code == CH_Z) || (char_code == CH_PLUS) ||
                       (char_code == CH_DASH);
   assign zone_phase = (char_code == CH_Z) ? PH_ZULU_DONE : PH_ZHOUR0;

   always_comb begin
      adv = cur_state;
      if (!cur_state.failed) begin
         case (cur_state.phase)
            PH_YEAR0, PH_YEAR1, PH_YEAR2, PH_YEAR3: begin
               if (!dig) begin
                  adv.failed = 1'b1;
               end else begin
                  case (cur_state.phase)
                     PH_YEAR0: adv.year_hi = {3'd0, d};
                     PH_YEAR1: adv.year_hi = 7'(cur_state.year_hi * 7'd10) + {3'd0, d};
                     PH_YEAR2: adv.year_lo = {3'd0, d};
                     default:  adv.year_lo = 7'(cur_state.year_lo * 7'd10) + {3'd0, d};
                  endcase
                  if (cur_state.phase == PH_YEAR3 && cur_state.year_hi == 7'd0 &&
                      adv.year_lo == 7'd0) begin
                     adv.failed = 1'b1;
                  end else begin
                     adv.phase = cur_state.phase + 5'd1;
                  end
               end
            end
            PH_DASH1, PH_DASH2: begin
               if (char_code != CH_DASH) adv.failed = 1'b1;
               else                      adv.phase  = cur_state.phase + 5'd1;
            end
            PH_TSEP: begin
               if (char_code != CH_T) adv.failed = 1'b1;
               else                   adv.phase  = cur_state.phase + 5'd1;
            end
            PH_COLON1, PH_COLON2, PH_ZCOLON: begin
               if (char_code != CH_COLON) adv.failed = 1'b1;
               else                       adv.phase  = cur_state.phase + 5'd1;
            end
            PH_MON0, PH_DAY0, PH_HOUR0, PH_MIN0, PH_SEC0, PH_ZHOUR0, PH_ZMIN0: begin
               if (!dig) begin
                  adv.failed = 1'b1;
               end else begin
                  adv.pair  = d;
                  adv.phase = cur_state.phase + 5'd1;
               end
            end
            PH_MON1, PH_DAY1, PH_HOUR1, PH_MIN1, PH_SEC1, PH_ZHOUR1, PH_ZMIN1: begin
               if (!dig) begin
                  adv.failed = 1'b1;
               end else begin
                  case (cur_state.phase)
                     PH_MON1:             adv.failed = (v == 7'd0) || (v > MAX_MONTH);
                     PH_DAY1:             adv.failed = (v == 7'd0) || (v > {2'd0, mdays});
                     PH_HOUR1, PH_ZHOUR1: adv.failed = (v > MAX_HOUR);
                     PH_SEC1:             adv.failed = (v > MAX_SECOND);
                     default:             adv.failed = (v > MAX_MINUTE);
                  endcase
                  if (cur_state.phase == PH_MON1) adv.month = v[3:0];
                  if (!adv.failed) adv.phase = cur_state.phase + 5'd1;
               end
            end
            PH_AFTER_SEC: begin
               if (char_code == CH_DOT) adv.phase  = PH_FRAC;
               else if (zone_ok)        adv.phase  = zone_phase;
               else                     adv.failed = 1'b1;
            end
            PH_FRAC: begin
               if (dig)                       adv.frac_seen = 1'b1;
               else if (!cur_state.frac_seen) adv.failed    = 1'b1;
               else if (zone_ok)              adv.phase     = zone_phase;
               else                           adv.failed    = 1'b1;
            end
            default: begin
               // Anything after a finished zone breaks the string.
               adv.failed = 1'b1;
            end
         endcase
      end
   end

   always_comb begin
      valid_res = is_last && !adv.failed &&
                  (adv.phase == PH_ZULU_DONE || adv.phase == PH_ZONE_DONE);
      nxt_state = is_last ? '0 : adv;
   end

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
   import tsc_pkg::*;

   localparam int unsigned CLOCK_PERIOD = 20;
   localparam int unsigned RESET_CYCLES = 11;
   localparam int unsigned PHASE_ITEMS  = 440;
   localparam int unsigned TAIL_CYCLES  = 20;
   localparam int unsigned CYCLE_LIMIT  = 300000;

   // Lowercase forms of the separators: close to legal, but always rejected.
   localparam logic [7:0] CH_T_LOWER = 8'h74;
   localparam logic [7:0] CH_Z_LOWER = 8'h7A;

   typedef struct packed {
      logic [7:0] ch;
      logic       is_final;
   } char_item_type;

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;   // [7:0] char_code
   logic       req_tlast  = 1'b0;    // is_last
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;            // [0] valid_res, [7:1] zero

   char_item_type pending_q[$];      // characters waiting for the driver
   logic [7:0]    draft[$];          // string being assembled by the generator
   logic          verdict_q[$];      // predicted verdicts, oldest first

   int unsigned pushed_count   = 0;
   int unsigned accepted_count = 0;
   int unsigned verdict_count  = 0;
   int unsigned error_count    = 0;
   int unsigned cycle_count    = 0;
   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;

   // Parser shadow state, advanced on every accepted character.
   logic [4:0]  st_phase     = PH_YEAR0;
   logic [13:0] st_year      = '0;
   logic [6:0]  st_month     = '0;
   logic [6:0]  st_pair      = '0;
   logic        st_frac_seen = 1'b0;
   logic        st_failed    = 1'b0;

   rfc3339_timestamp_check_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   task automatic flag_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      error_count++;
   endtask

   // Append one character to the string being assembled.
   task automatic add_char(input logic [7:0] c);
      draft = {draft, c};
   endtask

   // Zone lead character: 'Z' closes the string, a sign opens an offset.
   task automatic open_zone(input logic [7:0] c);
      if (c == CH_Z) begin
         st_phase = PH_ZULU_DONE;
      end else if (c == CH_PLUS || c == CH_DASH) begin
         st_phase = PH_ZHOUR0;
      end else begin
         st_failed = 1'b1;
      end
   endtask

   // Advance the shadow parser by one character; on the final character
   // queue the verdict and clear the state for the next string.
   task automatic track_timestamp(input logic [7:0] c, input logic is_final);
      logic       is_digit;
      logic [3:0] digit;
      logic [6:0] pair_val;
      logic       leap;
      logic [6:0] max_day;
      logic       verdict;
      is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
      digit    = is_digit ? 4'(c - CH_ZERO) : 4'd0;
      pair_val = 7'(st_pair * 10 + digit);
      if (!st_failed) begin
         case (st_phase)
            PH_YEAR0, PH_YEAR1, PH_YEAR2, PH_YEAR3: begin
               if (!is_digit) begin
                  st_failed = 1'b1;
               end else begin
                  st_year = 14'(st_year * 10 + digit);
                  if (st_phase == PH_YEAR3 && st_year == 0) st_failed = 1'b1;
                  else st_phase++;
               end
            end
            PH_DASH1, PH_DASH2: begin
               if (c != CH_DASH) st_failed = 1'b1;
               else st_phase++;
            end
            PH_TSEP: begin
               if (c != CH_T) st_failed = 1'b1;
               else st_phase++;
            end
            PH_COLON1, PH_COLON2, PH_ZCOLON: begin
               if (c != CH_COLON) st_failed = 1'b1;
               else st_phase++;
            end
            PH_MON0, PH_DAY0, PH_HOUR0, PH_MIN0, PH_SEC0, PH_ZHOUR0, PH_ZMIN0: begin
               if (!is_digit) begin
                  st_failed = 1'b1;
               end else begin
                  st_pair = 7'(digit);
                  st_phase++;
               end
            end
            PH_MON1, PH_DAY1, PH_HOUR1, PH_MIN1, PH_SEC1, PH_ZHOUR1, PH_ZMIN1: begin
               leap = (st_year % 4 == 0) && ((st_year % 100 != 0) || (st_year % 400 == 0));
               case (st_month)
                  7'd2:                     max_day = leap ? 7'd29 : 7'd28;
                  7'd4, 7'd6, 7'd9, 7'd11:  max_day = 7'd30;
                  default:                  max_day = 7'd31;
               endcase
               if (!is_digit) begin
                  st_failed = 1'b1;
               end else if (st_phase == PH_MON1) begin
                  if (pair_val == 0 || pair_val > MAX_MONTH) st_failed = 1'b1;
                  else st_month = pair_val;
               end else if (st_phase == PH_DAY1) begin
                  if (pair_val == 0 || pair_val > max_day) st_failed = 1'b1;
               end else if (st_phase == PH_HOUR1 || st_phase == PH_ZHOUR1) begin
                  if (pair_val > MAX_HOUR) st_failed = 1'b1;
               end else if (st_phase == PH_SEC1) begin
                  if (pair_val > MAX_SECOND) st_failed = 1'b1;
               end else begin
                  if (pair_val > MAX_MINUTE) st_failed = 1'b1;
               end
               if (!st_failed) st_phase++;
            end
            PH_AFTER_SEC: begin
               if (c == CH_DOT) st_phase = PH_FRAC;
               else open_zone(c);
            end
            PH_FRAC: begin
               if (is_digit) st_frac_seen = 1'b1;
               else if (!st_frac_seen) st_failed = 1'b1;
               else open_zone(c);
            end
            // Anything after a complete zone breaks the string.
            default: st_failed = 1'b1;
         endcase
      end
      if (is_final) begin
         verdict = !st_failed && (st_phase == PH_ZULU_DONE || st_phase == PH_ZONE_DONE);
         verdict_q = {verdict_q, verdict};
         st_phase     = PH_YEAR0;
         st_year      = '0;
         st_month     = '0;
         st_pair      = '0;
         st_frac_seen = 1'b0;
         st_failed    = 1'b0;
      end
   endtask

   // ---------------------------------------------------------------
   // String generation
   // ---------------------------------------------------------------

   task automatic add_digits(input int unsigned v, input int unsigned n);
      int unsigned p;
      p = 1;
      repeat (n - 1) p *= 10;
      repeat (n) begin
         add_char(CH_ZERO + 8'((v / p) % 10));
         p /= 10;
      end
   endtask

   // Mostly in range, with a bias to the bounds and now and then outside them.
   function automatic int unsigned pick_field(input int unsigned lo, input int unsigned hi);
      int unsigned r;
      r = $urandom_range(23);
      if (r == 0) return $urandom_range(hi + 1, 99);
      if (r == 1 && lo > 0) return 0;
      if (r < 6) return r[0] ? lo : hi;
      return $urandom_range(hi, lo);
   endfunction

   task automatic draft_text(input string s);
      draft.delete();
      foreach (s[i]) add_char(8'(s[i]));
   endtask

   // Hand the draft to the driver, tagging its final character.
   task automatic commit_draft();
      char_item_type item;
      foreach (draft[i]) begin
         item.ch       = draft[i];
         item.is_final = (i == draft.size() - 1);
         pending_q     = {pending_q, item};
      end
      pushed_count += draft.size();
   endtask

   // Build a timestamp-shaped string with random field values.
   task automatic draft_stamp();
      int unsigned year;
      int unsigned r;
      case ($urandom_range(11))
         0:       year = 0;
         1:       year = 1900;
         2:       year = 2000;
         3:       year = 2004;
         4:       year = 2100;
         5:       year = 2400;
         6:       year = 9999;
         7:       year = 1;
         default: year = $urandom_range(9999, 1);
      endcase
      draft.delete();
      add_digits(year, 4);
      add_char(CH_DASH);
      add_digits(($urandom_range(3) == 0) ? 2 : pick_field(1, 12), 2);
      add_char(CH_DASH);
      add_digits(($urandom_range(2) == 0) ? $urandom_range(31, 28) : pick_field(1, 31), 2);
      add_char(($urandom_range(29) == 0) ? CH_T_LOWER : CH_T);
      add_digits(pick_field(0, 23), 2);
      add_char(CH_COLON);
      add_digits(pick_field(0, 59), 2);
      add_char(CH_COLON);
      add_digits(pick_field(0, 60), 2);
      // Optional fraction; zero digits makes it empty.
      if ($urandom_range(9) < 3) begin
         add_char(CH_DOT);
         repeat ($urandom_range(4)) add_char(CH_ZERO + 8'($urandom_range(9)));
      end
      r = $urandom_range(19);
      if (r < 8) begin
         add_char(CH_Z);
      end else if (r == 8) begin
         add_char(CH_Z_LOWER);
      end else begin
         add_char(r[0] ? CH_PLUS : CH_DASH);
         add_digits(pick_field(0, 23), 2);
         add_char(CH_COLON);
         add_digits(pick_field(0, 59), 2);
      end
   endtask

   // Mostly stamps as built; the rest corrupted, cut short, overlong or noise.
   task automatic queue_random_string();
      int unsigned r;
      int unsigned keep;
      r = $urandom_range(99);
      draft_stamp();
      if (r < 62) begin
         // leave as built
      end else if (r < 72) begin
         draft[$urandom_range(draft.size() - 1)] = 8'($urandom_range(255));
      end else if (r < 80) begin
         keep = $urandom_range(draft.size() - 1, 1);
         while (draft.size() > keep) void'(draft.pop_back());
      end else if (r < 88) begin
         repeat ($urandom_range(3, 1)) add_char(8'($urandom_range(255)));
      end else begin
         draft.delete();
         repeat ($urandom_range(30, 1)) add_char(8'($urandom_range(255)));
      end
      commit_draft();
   endtask

   // ---------------------------------------------------------------
   // Driver: present pending characters; a held transfer keeps its data
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      char_item_type item;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         // Predict on the transfer that completes at this edge.
         if (req_tvalid && req_tready) begin
            track_timestamp(req_tdata, req_tlast);
            accepted_count++;
         end
         // Hold while a transfer is pending, otherwise offer the next one or idle.
         if (!req_tvalid || req_tready) begin
            if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               item = pending_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= item.ch;
               req_tlast  <= item.is_final;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Monitor: check each verdict transfer against the oldest prediction
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      logic want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (verdict_q.size() == 0) begin
            flag_mismatch($sformatf("verdict %0b arrived with none predicted",
                                    rsp_tdata[0]));
         end else begin
            want = verdict_q.pop_front();
            if (rsp_tdata[0] !== want)
               flag_mismatch($sformatf("verdict %0d: valid_res %b, predicted %b",
                                       verdict_count, rsp_tdata[0], want));
            if (rsp_tdata[7:1] !== 7'd0)
               flag_mismatch($sformatf("verdict %0d: padding bits %b not zero",
                                       verdict_count, rsp_tdata[7:1]));
         end
         verdict_count++;
      end
      // Stall the result channel at the rate of the current phase.
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Watchdog: abandon a run that stops making progress.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Sequencing: reset, then four traffic phases, each drained before the next
   // ---------------------------------------------------------------
   initial begin
      int unsigned target;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
            default: begin send_idle_pct = 7; recv_stall_pct = 7; end
         endcase
         if (ph == 0) begin
            // Largest legal field values throughout, with a leap second.
            draft_text("9999-12-31T23:59:60Z");
            commit_draft();
            // Year zero: fails on its last digit, then ends far too short.
            draft_text("0000");
            commit_draft();
            // One top-value byte as a whole string.
            draft.delete();
            add_char(8'hFF);
            commit_draft();
         end
         target = pushed_count + PHASE_ITEMS;
         while (pushed_count < target) queue_random_string();
         // Stop generating until every character is accepted and every predicted verdict seen.
         while (accepted_count != pushed_count || verdict_q.size() != 0)
            @(posedge clock);
      end
      // Let any stray output show before the verdict.
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
